// ----- hdl/program_stream_video_demux_assert.svh -----
// ----------------------------------------------------------------------------
// Program stream video demux assertion macros
// Concurrent assertion shorthands, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef PROGRAM_STREAM_VIDEO_DEMUX_ASSERT_SVH
`define PROGRAM_STREAM_VIDEO_DEMUX_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PSVD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define PSVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/psvd_pkg.sv -----
// ----------------------------------------------------------------------------
// psvd_pkg
// Shared types and constants of the program stream video demux.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psvd_pkg;

   localparam logic [7:0] PACK_CODE      = 8'hBA;
   localparam logic [7:0] END_CODE       = 8'hB9;
   localparam logic [7:0] FIRST_LEN_CODE = 8'hBB;
   localparam logic [7:0] VIDEO_CODE_LO  = 8'hE0;
   localparam logic [7:0] VIDEO_CODE_HI  = 8'hEF;
   localparam logic [7:0] PES_MARK_MASK  = 8'hC0;
   localparam logic [7:0] PES_MARK       = 8'h80;
   localparam logic [2:0] STUFF_MASK     = 3'h7;

   localparam int PTS_WIDTH  = 33;
   localparam int OFS_WIDTH  = 17;
   localparam int LEN_WIDTH  = 16;
   localparam int HLEN_WIDTH = 9;

   // byte positions counted from the first byte of the start code
   localparam logic [OFS_WIDTH-1:0] OFS_PACK_FIRST = 17'd4;
   localparam logic [OFS_WIDTH-1:0] OFS_PACK_STUFF = 17'd13;
   localparam logic [OFS_WIDTH-1:0] OFS_BODY_FIRST = 17'd6;
   localparam logic [OFS_WIDTH-1:0] OFS_PES_FLAGS  = 17'd7;
   localparam logic [OFS_WIDTH-1:0] OFS_HDR_LEN    = 17'd8;
   localparam logic [OFS_WIDTH-1:0] OFS_PTS_0      = 17'd9;
   localparam logic [OFS_WIDTH-1:0] OFS_PTS_1      = 17'd10;
   localparam logic [OFS_WIDTH-1:0] OFS_PTS_2      = 17'd11;
   localparam logic [OFS_WIDTH-1:0] OFS_PTS_3      = 17'd12;
   localparam logic [OFS_WIDTH-1:0] OFS_PTS_4      = 17'd13;
   localparam logic [OFS_WIDTH-1:0] OFS_LAST_BIAS  = 17'd5;

   localparam logic [HLEN_WIDTH-1:0] HDR_LEN_BIAS  = 9'd9;
   localparam logic [HLEN_WIDTH-1:0] HDR_LEN_PTS   = 9'd14;
   localparam logic [LEN_WIDTH-1:0]  PKT_LEN_PES   = 16'd3;
   localparam logic [LEN_WIDTH-1:0]  PKT_LEN_PTS   = 16'd8;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } psvd_word_type;

   typedef struct packed {
      logic                 valid;
      logic [7:0]           payload_byte;
      logic [3:0]           stream_number;
      logic [PTS_WIDTH-1:0] pts;
      logic                 pts_valid;
      logic                 first_of_payload;
      logic                 last_of_payload;
   } psvd_result_type;

endpackage

// ----- hdl/psvd_in_stage.sv -----
// ----------------------------------------------------------------------------
// psvd_in_stage
// Input word register; advances into the parser when the result side is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psvd_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_stream_byte,
   input  logic                   slot_free,
   output logic                   advance,
   output psvd_pkg::psvd_word_type word
);
   import psvd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;

   assign advance   = valid_ff && slot_free;
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_stream_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign word.valid = valid_ff;
   assign word.data  = data_ff;

endmodule

// ----- hdl/psvd_parser.sv -----
// ----------------------------------------------------------------------------
// psvd_parser
// Start code hunt, element skipping and video PES payload extraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psvd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  psvd_pkg::psvd_word_type  word,
   output psvd_pkg::psvd_result_type result
);
   import psvd_pkg::*;

   typedef enum logic [6:0] {
      PH_HUNT   = 7'b0000001,
      PH_CODE   = 7'b0000010,
      PH_PACK   = 7'b0000100,
      PH_STUFF  = 7'b0001000,
      PH_LEN_HI = 7'b0010000,
      PH_LEN_LO = 7'b0100000,
      PH_BODY   = 7'b1000000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [1:0]            zero_run_ff, zero_run_in;
   logic [7:0]            start_code_ff, start_code_in;
   logic [OFS_WIDTH-1:0]  offset_ff, offset_in;
   logic [LEN_WIDTH-1:0]  pkt_len_ff, pkt_len_in;
   logic [HLEN_WIDTH-1:0] hdr_len_ff, hdr_len_in;
   logic [1:0]            flags_ff, flags_in;
   logic [PTS_WIDTH-1:0]  pts_ff, pts_in;
   logic [2:0]            stuff_ff, stuff_in;
   logic                  first_ff, first_in;

   logic [7:0]           b;
   logic                 last;
   logic                 has_pts;
   logic                 emit;

   assign b       = word.data;
   assign last    = offset_ff == ({1'b0, pkt_len_ff} + OFS_LAST_BIAS);
   assign has_pts = flags_ff[0] && (hdr_len_ff >= HDR_LEN_PTS) && (pkt_len_ff >= PKT_LEN_PTS);
   assign emit    = (phase_ff == PH_BODY) && flags_ff[1] && (offset_ff > OFS_HDR_LEN)
                    && (offset_ff >= {8'b0, hdr_len_ff});

   always_comb begin
      phase_in      = phase_ff;
      zero_run_in   = zero_run_ff;
      start_code_in = start_code_ff;
      offset_in     = offset_ff;
      pkt_len_in    = pkt_len_ff;
      hdr_len_in    = hdr_len_ff;
      flags_in      = flags_ff;
      pts_in        = pts_ff;
      stuff_in      = stuff_ff;
      first_in      = first_ff;
      case (phase_ff)
         PH_CODE: begin
            start_code_in = b;
            if (b == PACK_CODE) begin
               phase_in  = PH_PACK;
               offset_in = OFS_PACK_FIRST;
            end else if (b == END_CODE || b < FIRST_LEN_CODE) begin
               phase_in    = PH_HUNT;
               zero_run_in = 2'd0;
            end else begin
               phase_in = PH_LEN_HI;
            end
         end
         PH_PACK: begin
            if (offset_ff == OFS_PACK_STUFF) begin
               stuff_in = b[2:0] & STUFF_MASK;
               if ((b[2:0] & STUFF_MASK) == 3'd0) begin
                  phase_in    = PH_HUNT;
                  zero_run_in = 2'd0;
               end else begin
                  phase_in = PH_STUFF;
               end
            end else begin
               offset_in = offset_ff + 17'd1;
            end
         end
         PH_STUFF: begin
            stuff_in = stuff_ff - 3'd1;
            if (stuff_ff == 3'd1) begin
               phase_in    = PH_HUNT;
               zero_run_in = 2'd0;
            end
         end
         PH_LEN_HI: begin
            pkt_len_in = {b, 8'h00};
            phase_in   = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            pkt_len_in = {pkt_len_ff[15:8], b};
            offset_in  = OFS_BODY_FIRST;
            hdr_len_in = '0;
            flags_in   = 2'b00;
            pts_in     = '0;
            first_in   = 1'b1;
            if ({pkt_len_ff[15:8], b} == 16'd0) begin
               phase_in    = PH_HUNT;
               zero_run_in = 2'd0;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (offset_ff == OFS_BODY_FIRST) begin
               if (start_code_ff inside {[VIDEO_CODE_LO:VIDEO_CODE_HI]}
                   && pkt_len_ff >= PKT_LEN_PES && (b & PES_MARK_MASK) == PES_MARK) begin
                  flags_in[1] = 1'b1;
               end
            end else if (offset_ff == OFS_PES_FLAGS) begin
               if (b[7]) begin
                  flags_in[0] = 1'b1;
               end
            end else if (offset_ff == OFS_HDR_LEN) begin
               hdr_len_in = HDR_LEN_BIAS + {1'b0, b};
            end else if (offset_ff == OFS_PTS_0) begin
               pts_in = {b[3:1], 30'b0};
            end else if (offset_ff == OFS_PTS_1) begin
               pts_in = pts_ff | (33'(b) << 22);
            end else if (offset_ff == OFS_PTS_2) begin
               pts_in = pts_ff | (33'(b[7:1]) << 15);
            end else if (offset_ff == OFS_PTS_3) begin
               pts_in = pts_ff | (33'(b) << 7);
            end else if (offset_ff == OFS_PTS_4) begin
               pts_in = pts_ff | 33'(b[7:1]);
            end
            if (emit) begin
               first_in = 1'b0;
            end
            if (last) begin
               phase_in    = PH_HUNT;
               zero_run_in = 2'd0;
            end else begin
               offset_in = offset_ff + 17'd1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (b == 8'h00) begin
               if (zero_run_ff < 2'd2) begin
                  zero_run_in = zero_run_ff + 2'd1;
               end
            end else if (b == 8'h01 && zero_run_ff >= 2'd2) begin
               zero_run_in = 2'd0;
               phase_in    = PH_CODE;
            end else begin
               zero_run_in = 2'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         zero_run_ff   <= 2'd0;
         start_code_ff <= 8'h00;
         offset_ff     <= '0;
         pkt_len_ff    <= '0;
         hdr_len_ff    <= '0;
         flags_ff      <= 2'b00;
         pts_ff        <= '0;
         stuff_ff      <= 3'd0;
         first_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         zero_run_ff   <= zero_run_in;
         start_code_ff <= start_code_in;
         offset_ff     <= offset_in;
         pkt_len_ff    <= pkt_len_in;
         hdr_len_ff    <= hdr_len_in;
         flags_ff      <= flags_in;
         pts_ff        <= pts_in;
         stuff_ff      <= stuff_in;
         first_ff      <= first_in;
      end
   end

   assign result.valid            = word.valid && emit;
   assign result.payload_byte     = b;
   assign result.stream_number    = start_code_ff[3:0];
   assign result.pts              = has_pts ? pts_ff : '0;
   assign result.pts_valid        = has_pts;
   assign result.first_of_payload = first_ff;
   assign result.last_of_payload  = last;

endmodule

// ----- hdl/psvd_out_stage.sv -----
// ----------------------------------------------------------------------------
// psvd_out_stage
// Result word register in front of the rsp channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psvd_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  psvd_pkg::psvd_result_type result,
   output logic                      slot_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_payload_byte,
   output logic [3:0]                rsp_stream_number,
   output logic [psvd_pkg::PTS_WIDTH-1:0] rsp_pts,
   output logic                      rsp_pts_valid,
   output logic                      rsp_first_of_payload,
   output logic                      rsp_last_of_payload
);
   import psvd_pkg::*;

   logic            valid_ff, valid_in;
   psvd_result_type data_ff, data_in;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = result.valid;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_payload_byte     = data_ff.payload_byte;
   assign rsp_stream_number    = data_ff.stream_number;
   assign rsp_pts              = data_ff.pts;
   assign rsp_pts_valid        = data_ff.pts_valid;
   assign rsp_first_of_payload = data_ff.first_of_payload;
   assign rsp_last_of_payload  = data_ff.last_of_payload;

endmodule

// ----- hdl/program_stream_video_demux.sv -----
// ----------------------------------------------------------------------------
// program_stream_video_demux
// Takes one program stream byte per word and returns video payload bytes
// tagged with stream number, time stamp and first/last marks. It accepts a
// byte every cycle; a byte passes an input register and then the result
// register before its payload word is offered on rsp. Input stalls only
// while a finished result is held by rsp_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "program_stream_video_demux_assert.svh"

module program_stream_video_demux (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_stream_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_payload_byte,
   output logic [3:0]                     rsp_stream_number,
   output logic [psvd_pkg::PTS_WIDTH-1:0] rsp_pts,
   output logic                           rsp_pts_valid,
   output logic                           rsp_first_of_payload,
   output logic                           rsp_last_of_payload
);
   import psvd_pkg::*;

   psvd_word_type   word;
   psvd_result_type result;
   logic            advance;
   logic            slot_free;

   psvd_in_stage u_in (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .slot_free       (slot_free),
      .advance         (advance),
      .word            (word)
   );

   psvd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (word),
      .result  (result)
   );

   psvd_out_stage u_out (
      .clock                (clock),
      .reset                (reset),
      .advance              (advance),
      .result               (result),
      .slot_free            (slot_free),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_stream_number    (rsp_stream_number),
      .rsp_pts              (rsp_pts),
      .rsp_pts_valid        (rsp_pts_valid),
      .rsp_first_of_payload (rsp_first_of_payload),
      .rsp_last_of_payload  (rsp_last_of_payload)
   );

   `PSVD_ASSERT_NOW(a_pts_zero, clock, reset, rsp_valid && !rsp_pts_valid, rsp_pts == '0, "pts set without pts_valid")
   `PSVD_ASSERT_NOW(a_stall_held, clock, reset, !req_ready, word.valid && !slot_free, "input stalled without cause")
   `PSVD_ASSERT_NEXT(a_result_lands, clock, reset, advance && result.valid, rsp_valid, "result lost")

endmodule
